[hdl/dpbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dpbp_pkg;

    localparam int MAX_METHODS_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLANNING_ENABLED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARAMETER_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLATION_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LIMIT     = 3'd4;

    localparam logic [31:0] BUCKET_LIMIT_RST = 32'd4096;

    // bytes taken by a uleb128 encoding of a 32-bit value
    function automatic logic [2:0] uleb_len(input logic [31:0] v);
        logic [2:0] n;
        n = 3'd1;
        if (v >= 32'h0000_0080) n = 3'd2;
        if (v >= 32'h0000_4000) n = 3'd3;
        if (v >= 32'h0020_0000) n = 3'd4;
        if (v >= 32'h1000_0000) n = 3'd5;
        return n;
    endfunction

endpackage

`default_nettype wire

[hdl/debug_program_bucket_planner_core.sv]
// Methods are loaded one word per cycle (start high while busy is low), largest size first;
// the word marked last closes the set and raises busy. Planning then runs a forward pass per
// method (one shared 32-step restoring divider computes each method's user bound), a
// backward grouping pass per method (one port per memory, registered reads), and an
// emission step per result. Results come out one per strobe and cannot be stalled; the
// last carries o_last_result, and busy drops in the cycle it is shown. With planning off
// or a faulty load the passes are skipped and only emission runs.
`timescale 1ns / 1ps
`default_nettype none

module debug_program_bucket_planner_core #(
    parameter int MAX_METHODS = dpbp_pkg::MAX_METHODS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dpbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dpbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [31:0]                     i_method_size,
    input  wire logic [31:0]                     i_normal_size,
    input  wire logic                            i_last,
    output logic                                 o_valid,
    output logic [5:0]                           o_method_index,
    output logic                                 o_has_program,
    output logic [5:0]                           o_program_index,
    output logic [31:0]                          o_program_length,
    output logic [6:0]                           o_program_users,
    output logic [32:0]                          o_program_bytes,
    output logic [6:0]                           o_first_shared,
    output logic [39:0]                          o_total_bytes,
    output logic [39:0]                          o_total_footprint,
    output logic                                 o_input_error,
    output logic                                 o_last_result
);

    localparam int AW = (MAX_METHODS > 1) ? $clog2(MAX_METHODS) : 1;
    localparam int EW = $clog2(MAX_METHODS + 1);
    localparam int KW = $clog2(MAX_METHODS + 2);
    localparam logic [EW-1:0] MAX_E   = EW'(MAX_METHODS);
    localparam logic [KW-1:0] UNBOUND = KW'(MAX_METHODS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FRD, S_FLD, S_FDIV, S_FWR, S_BINIT,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_E0, S_E1
    } t_state;

    // configuration
    logic        r_en;
    logic [7:0]  r_pcount;
    logic [31:0] r_fline;
    logic [47:0] r_ilimit;
    logic [31:0] r_blimit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_pcount <= '0;
            r_fline  <= '0;
            r_ilimit <= '0;
            r_blimit <= dpbp_pkg::BUCKET_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpbp_pkg::CFG_PLANNING_ENABLED: r_en     <= i_cfg_data[0];
                dpbp_pkg::CFG_PARAMETER_COUNT:  r_pcount <= i_cfg_data[7:0];
                dpbp_pkg::CFG_FIRST_LINE:       r_fline  <= i_cfg_data[31:0];
                dpbp_pkg::CFG_INFLATION_LIMIT:  r_ilimit <= i_cfg_data[47:0];
                dpbp_pkg::CFG_BUCKET_LIMIT:     r_blimit <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // fixed part of a program's encoded size
    logic [8:0] pb_const;
    assign pb_const = 9'(dpbp_pkg::uleb_len(r_fline)) + 9'(dpbp_pkg::uleb_len(32'(r_pcount)))
                    + 9'(r_pcount) + 9'd1;

    t_state        r_state;
    logic [EW-1:0] r_count, r_n, r_i, r_k, r_best, r_greedy, r_end, r_next, r_prev_rb;
    logic [39:0]   r_ntot_acc, r_ntot, r_suff, r_bbytes, r_foot, r_tf, r_tb;
    logic [40:0]   r_total;
    logic          r_fit;
    logic          r_fault, r_err, r_planned;
    logic [31:0]   r_last_size, r_szi, r_nmi, r_prev, r_len;
    logic [31:0]   r_rem, r_quo;
    logic [4:0]    r_dcnt;
    logic [38:0]   r_prod;
    logic [EW-1:0] r_users;
    logic [5:0]    r_prog;

    // memories
    logic [31:0]   size_mem [MAX_METHODS];
    logic [31:0]   norm_mem [MAX_METHODS];
    logic [EW-1:0] rb_mem   [MAX_METHODS];
    logic [KW-1:0] cap_mem  [MAX_METHODS];
    logic [EW-1:0] ge_mem   [MAX_METHODS+1];
    logic [39:0]   tf_mem   [MAX_METHODS+1];
    logic [39:0]   tb_mem   [MAX_METHODS+1];
    logic [31:0]   size_q, norm_q;
    logic [EW-1:0] rb_q, ge_q;
    logic [KW-1:0] cap_q;
    logic [39:0]   tf_q, tb_q;

    logic [AW-1:0] rd_addr;
    logic [EW-1:0] ge_addr;

    logic          accept, store;
    logic          fault_next;
    logic [EW-1:0] count_next;
    logic [39:0]   ntot_next;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;
    assign store  = accept && (r_count < MAX_E);
    assign fault_next = r_fault || (r_count >= MAX_E)
                     || (r_count != '0 && i_method_size > r_last_size);
    assign count_next = store ? r_count + EW'(1) : r_count;
    assign ntot_next  = store ? r_ntot_acc + 40'(i_normal_size) : r_ntot_acc;

    always_comb begin
        case (r_state)
            S_B2:    rd_addr = (r_greedy < r_n) ? r_greedy[AW-1:0] : '0;
            S_E0:    rd_addr = r_k[AW-1:0];
            default: rd_addr = r_i[AW-1:0];
        endcase
        case (r_state)
            S_B2:    ge_addr = r_greedy;
            S_E0:    ge_addr = r_k;
            default: ge_addr = r_end;
        endcase
    end

    // divider step and user bound
    logic [32:0] rem_sh;
    logic        q_bit;
    logic [31:0] quo_fin;
    logic [KW-1:0] cap_val;
    assign rem_sh  = {r_rem, r_quo[31]};
    assign q_bit   = (rem_sh >= {1'b0, r_szi});
    assign quo_fin = r_quo;
    always_comb begin
        if (r_szi == '0 || quo_fin > 32'(UNBOUND)) cap_val = UNBOUND;
        else if (quo_fin == '0)                    cap_val = KW'(1);
        else                                       cap_val = KW'(quo_fin);
    end

    // group end from the greedy split
    logic [KW-1:0] rem_n, take, ne_k, earliest;
    logic [EW-1:0] end_v, end_max;
    always_comb begin
        rem_n = KW'(r_n - r_i);
        take  = (rem_n < cap_q) ? rem_n : cap_q;
        ne_k  = KW'(ge_q);
        earliest = (ne_k > cap_q) ? ne_k - cap_q : '0;
        end_max  = (rb_q > EW'(earliest)) ? rb_q : EW'(earliest);
        end_v = r_greedy;
        if (r_greedy < r_n && size_q < r_szi) begin
            end_v = end_max;
            if (end_v <= r_i) end_v = r_i + EW'(1);
            if (end_v > r_greedy) end_v = r_greedy;
        end
    end

    // emission leader tracking
    logic          e_has, e_lead;
    logic [31:0]   e_len;
    logic [EW-1:0] e_users;
    logic [5:0]    e_prog;
    always_comb begin
        e_has   = r_planned && (r_k >= r_best);
        e_lead  = e_has && (r_k == r_next);
        e_len   = e_lead ? size_q : r_len;
        e_users = e_lead ? ge_q - r_k : r_users;
        e_prog  = (e_lead && r_k != r_best) ? r_prog + 6'd1 : r_prog;
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            size_mem[r_count[AW-1:0]] <= i_method_size;
            norm_mem[r_count[AW-1:0]] <= i_normal_size;
        end
        if (r_state == S_FWR) begin
            rb_mem[r_i[AW-1:0]]  <= (r_i != '0 && r_szi == r_prev) ? r_prev_rb : r_i;
            cap_mem[r_i[AW-1:0]] <= cap_val;
        end
        if (r_state == S_BINIT) begin
            ge_mem[r_n] <= r_n;
            tf_mem[r_n] <= '0;
            tb_mem[r_n] <= '0;
        end else if (r_state == S_B5) begin
            ge_mem[r_i] <= r_end;
            tf_mem[r_i] <= 40'(r_prod) + tf_q;
            tb_mem[r_i] <= 40'(r_szi) + 40'(pb_const) + tb_q;
        end
        size_q <= size_mem[rd_addr];
        norm_q <= norm_mem[rd_addr];
        rb_q   <= rb_mem[rd_addr];
        cap_q  <= cap_mem[rd_addr];
        ge_q   <= ge_mem[ge_addr];
        tf_q   <= tf_mem[ge_addr];
        tb_q   <= tb_mem[ge_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ntot_acc <= '0;
            r_fault    <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (store) r_last_size <= i_method_size;
                        if (i_last) begin
                            r_n        <= count_next;
                            r_ntot     <= ntot_next;
                            r_err      <= fault_next;
                            r_planned  <= r_en && !fault_next && count_next != '0;
                            r_best     <= count_next;
                            r_bbytes   <= ntot_next;
                            r_foot     <= '0;
                            r_i        <= '0;
                            r_k        <= '0;
                            r_count    <= '0;
                            r_ntot_acc <= '0;
                            r_fault    <= 1'b0;
                            r_state <= (r_en && !fault_next && count_next != '0) ? S_FRD : S_E0;
                        end else begin
                            r_count    <= count_next;
                            r_ntot_acc <= ntot_next;
                            r_fault    <= fault_next;
                        end
                    end
                end
                S_FRD: r_state <= S_FLD;
                S_FLD: begin
                    r_szi  <= size_q;
                    r_rem  <= '0;
                    r_quo  <= r_blimit;
                    r_dcnt <= '0;
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    r_rem  <= q_bit ? 32'(rem_sh - {1'b0, r_szi}) : rem_sh[31:0];
                    r_quo  <= {r_quo[30:0], q_bit};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) r_state <= S_FWR;
                end
                S_FWR: begin
                    r_prev    <= r_szi;
                    r_prev_rb <= (r_i != '0 && r_szi == r_prev) ? r_prev_rb : r_i;
                    if (r_i == r_n - EW'(1)) begin
                        r_state <= S_BINIT;
                    end else begin
                        r_i <= r_i + EW'(1);
                        r_state <= S_FRD;
                    end
                end
                S_BINIT: begin
                    r_i    <= r_n - EW'(1);
                    r_suff <= '0;
                    r_state <= S_B0;
                end
                S_B0: r_state <= S_B1;
                S_B1: begin
                    r_szi    <= size_q;
                    r_nmi    <= norm_q;
                    r_greedy <= r_i + EW'(take);
                    r_state  <= S_B2;
                end
                S_B2: r_state <= S_B3;
                S_B3: begin
                    r_end   <= end_v;
                    r_state <= S_B4;
                end
                S_B4: begin
                    r_prod  <= 39'(r_szi) * 39'(r_end - r_i);
                    r_state <= S_B5;
                end
                S_B5: begin
                    r_tf    <= 40'(r_prod) + tf_q;
                    r_tb    <= 40'(r_szi) + 40'(pb_const) + tb_q;
                    r_suff  <= r_suff + 40'(r_nmi);
                    r_state <= S_B6;
                end
                S_B6: begin
                    r_total <= 41'(r_ntot) - 41'(r_suff) + 41'(r_tb);
                    r_fit   <= (48'(r_tf) <= r_ilimit);
                    r_state <= S_B7;
                end
                S_B7: begin
                    // later suffix wins ties: update on strictly less only
                    if (r_fit && r_total < 41'(r_bbytes)) begin
                        r_bbytes <= r_total[39:0];
                        r_best   <= r_i;
                        r_foot   <= r_tf;
                    end
                    if (r_i == '0) begin
                        r_state <= S_E0;
                    end else begin
                        r_i <= r_i - EW'(1);
                        r_state <= S_B0;
                    end
                end
                S_E0: begin
                    if (r_k == '0) begin
                        r_next <= r_best;
                        r_prog <= '0;
                    end
                    r_state <= S_E1;
                end
                S_E1: begin
                    r_len   <= e_len;
                    r_users <= e_users;
                    r_prog  <= e_prog;
                    if (e_lead) r_next <= ge_q;
                    o_valid           <= 1'b1;
                    o_method_index    <= 6'(r_k);
                    o_has_program     <= e_has;
                    o_program_index   <= e_has ? e_prog : '0;
                    o_program_length  <= e_has ? e_len : '0;
                    o_program_users   <= e_has ? 7'(e_users) : '0;
                    o_program_bytes   <= e_has ? 33'(e_len) + 33'(pb_const) : '0;
                    o_first_shared    <= 7'(r_best);
                    o_total_bytes     <= r_bbytes;
                    o_total_footprint <= r_foot;
                    o_input_error     <= r_err;
                    o_last_result     <= (r_k == r_n - EW'(1));
                    if (r_k == r_n - EW'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + EW'(1);
                        r_state <= S_E0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last) |=> o_busy)
        else $error("closing word did not start planning");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_result) |-> o_busy)
        else $error("run ended before its final result");

    a_no_prog_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_program) |-> (!o_input_error && o_program_users != 7'd0))
        else $error("program assigned on a faulty load or with no users");

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int NMAX = 64;
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic [5:0]  method_index;
        logic        has_program;
        logic [5:0]  program_index;
        logic [31:0] program_length;
        logic [6:0]  program_users;
        logic [32:0] program_bytes;
        logic [6:0]  first_shared;
        logic [39:0] total_bytes;
        logic [39:0] total_footprint;
        logic        input_error;
        logic        last_result;
    } t_plan_word;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [dpbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dpbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic [31:0] method_size = '0;
    logic [31:0] normal_size = '0;
    logic last = 1'b0;
    logic busy, valid;
    logic [5:0]  got_method_index;
    logic        got_has_program;
    logic [5:0]  got_program_index;
    logic [31:0] got_program_length;
    logic [6:0]  got_program_users;
    logic [32:0] got_program_bytes;
    logic [6:0]  got_first_shared;
    logic [39:0] got_total_bytes;
    logic [39:0] got_total_footprint;
    logic        got_input_error;
    logic        got_last_result;
    t_plan_word  got;

    debug_program_bucket_planner_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_start(start), .o_busy(busy),
        .i_method_size(method_size), .i_normal_size(normal_size), .i_last(last),
        .o_valid(valid),
        .o_method_index(got_method_index), .o_has_program(got_has_program),
        .o_program_index(got_program_index), .o_program_length(got_program_length),
        .o_program_users(got_program_users), .o_program_bytes(got_program_bytes),
        .o_first_shared(got_first_shared), .o_total_bytes(got_total_bytes),
        .o_total_footprint(got_total_footprint), .o_input_error(got_input_error),
        .o_last_result(got_last_result)
    );

    assign got = {got_method_index, got_has_program, got_program_index, got_program_length,
                  got_program_users, got_program_bytes, got_first_shared, got_total_bytes,
                  got_total_footprint, got_input_error, got_last_result};

    initial forever #2 clk = ~clk;

    // predictor state
    logic        plan_on;
    logic [7:0]  param_cnt;
    logic [31:0] line0;
    logic [47:0] infl_limit;
    logic [31:0] bkt_limit;
    logic [31:0] sizes [NMAX];
    logic [31:0] normals [NMAX];
    int          loaded;
    logic [39:0] normal_sum;
    logic        fault;

    t_plan_word expected_plan[$];
    int  fails = 0;
    int  quiet = 0;
    bit  calm = 0;

    function automatic int uleb_bytes(input logic [31:0] v);
        int n;
        n = 1;
        while (v >= 128) begin
            v = v >> 7;
            n++;
        end
        return n;
    endfunction

    function automatic logic [39:0] enc_bytes(input logic [31:0] sz);
        return 40'(uleb_bytes(line0)) + 40'(uleb_bytes({24'd0, param_cnt}))
            + 40'(param_cnt) + 40'(sz) + 40'd1;
    endfunction

    function automatic int bound_of(input logic [31:0] sz);
        logic [31:0] q;
        if (sz == 0) return NMAX + 1;
        q = bkt_limit / sz;
        if (q < 1) q = 1;
        if (q > NMAX + 1) q = NMAX + 1;
        return int'(q);
    endfunction

    // build the per-method plan words once the set closes
    task automatic plan_set();
        int n, best, prg, nxt, st, cap, greedy, gend, ne, room, earliest;
        int run0 [NMAX];
        int gend_of [NMAX + 1];
        logic [39:0] foot [NMAX + 1];
        logic [39:0] byts [NMAX + 1];
        logic [39:0] best_bytes, sfx, tot, fp;
        bit planned;
        t_plan_word w;
        n = loaded;
        best = n;
        best_bytes = normal_sum;
        fp = 0;
        planned = plan_on && !fault && n > 0;
        if (planned) begin
            for (int i = 0; i < n; i++)
                run0[i] = (i > 0 && sizes[i] == sizes[i-1]) ? run0[i-1] : i;
            gend_of[n] = n;
            foot[n] = 0;
            byts[n] = 0;
            sfx = 0;
            for (int i = n - 1; i >= 0; i--) begin
                cap = bound_of(sizes[i]);
                greedy = i + ((n - i) < cap ? (n - i) : cap);
                gend = greedy;
                if (greedy < n && sizes[greedy] < sizes[i]) begin
                    ne = gend_of[greedy];
                    room = bound_of(sizes[greedy]);
                    earliest = ne > room ? ne - room : 0;
                    gend = run0[greedy] > earliest ? run0[greedy] : earliest;
                    if (gend <= i) gend = i + 1;
                    if (gend > greedy) gend = greedy;
                end
                gend_of[i] = gend;
                foot[i] = 40'(64'(sizes[i]) * (gend - i)) + foot[gend];
                byts[i] = enc_bytes(sizes[i]) + byts[gend];
                sfx += normals[i];
                if ({8'd0, foot[i]} > infl_limit) continue;
                tot = normal_sum - sfx + byts[i];
                if (tot < best_bytes) begin
                    best_bytes = tot;
                    best = i;
                end
            end
            fp = foot[best];
        end
        prg = 0;
        nxt = best;
        for (int k = 0; k < n; k++) begin
            w = '0;
            w.method_index = 6'(k);
            if (planned && k >= best) begin
                if (k == nxt) begin
                    if (k != best) prg++;
                    nxt = gend_of[k];
                end
                st = best;
                while (gend_of[st] <= k) st = gend_of[st];
                w.has_program = 1'b1;
                w.program_index = 6'(prg);
                w.program_length = sizes[st];
                w.program_users = 7'(gend_of[st] - st);
                w.program_bytes = 33'(enc_bytes(sizes[st]));
            end
            w.first_shared = 7'(best);
            w.total_bytes = best_bytes;
            w.total_footprint = fp;
            w.input_error = fault;
            w.last_result = (k + 1 == n);
            expected_plan.insert(expected_plan.size(), w);
        end
        loaded = 0;
        normal_sum = 0;
        fault = 1'b0;
    endtask

    task automatic predict_word(input logic [31:0] sz, input logic [31:0] nm, input logic lst);
        if (loaded >= NMAX) begin
            fault = 1'b1;
        end else begin
            if (loaded > 0 && sz > sizes[loaded-1]) fault = 1'b1;
            sizes[loaded] = sz;
            normals[loaded] = nm;
            normal_sum += nm;
            loaded++;
        end
        if (lst) plan_set();
    endtask

    // drop start for the idle cycles
    task automatic idle_gap();
        if (!calm) begin
            while ($urandom_range(99) < 35) begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_word(input logic [31:0] sz, input logic [31:0] nm, input logic lst);
        idle_gap();
        start <= 1'b1;
        method_size <= sz;
        normal_size <= nm;
        last <= lst;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_word(sz, nm, lst);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_plan.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dpbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            dpbp_pkg::CFG_PLANNING_ENABLED: plan_on = val[0];
            dpbp_pkg::CFG_PARAMETER_COUNT:  param_cnt = val[7:0];
            dpbp_pkg::CFG_FIRST_LINE:       line0 = val[31:0];
            dpbp_pkg::CFG_INFLATION_LIMIT:  infl_limit = val;
            dpbp_pkg::CFG_BUCKET_LIMIT:     bkt_limit = val[31:0];
            default: ;
        endcase
    endtask

    task automatic setup(input logic en, input logic [7:0] pc, input logic [31:0] fl,
                         input logic [47:0] il, input logic [31:0] bl);
        write_reg(dpbp_pkg::CFG_PLANNING_ENABLED, {47'd0, en});
        write_reg(dpbp_pkg::CFG_PARAMETER_COUNT, {40'd0, pc});
        write_reg(dpbp_pkg::CFG_FIRST_LINE, {16'd0, fl});
        write_reg(dpbp_pkg::CFG_INFLATION_LIMIT, il);
        write_reg(dpbp_pkg::CFG_BUCKET_LIMIT, {16'd0, bl});
        cfg_we <= 1'b0;
    endtask

    // random set, descending but in mode 2, which may raise a size; sizes mostly small so groups share often
    task automatic random_set(input int n, input int mode);
        logic [31:0] sz, nm;
        sz = (mode == 0) ? $urandom_range(40) : $urandom;
        for (int i = 0; i < n; i++) begin
            nm = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
            send_word(sz, nm, i == n - 1);
            if ($urandom_range(9) == 0 && mode == 2) sz = sz + $urandom_range(5);
            else if ($urandom_range(2) == 0) sz = (sz > 3) ? sz - $urandom_range(3) : sz;
        end
    endtask

    task automatic test_directed();
        setup(1'b1, 8'd255, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd4096);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 32'd0, 1'b0);
        send_word(32'd100, 32'd500, 1'b0);
        send_word(32'd100, 32'd500, 1'b0);
        send_word(32'd0, 32'd200, 1'b0);
        send_word(32'd0, 32'd200, 1'b1);
        drain();
        // rising size flags an order fault
        send_word(32'd5, 32'd10, 1'b0);
        send_word(32'd9, 32'd10, 1'b1);
        drain();
        // zero bucket limit: one user per group
        setup(1'b1, 8'd0, 32'd0, 48'd1000, 32'd0);
        send_word(32'd3, 32'd100, 1'b0);
        send_word(32'd3, 32'd100, 1'b0);
        send_word(32'd2, 32'd100, 1'b1);
        drain();
        // planning off
        setup(1'b0, 8'd3, 32'd200, 48'd0, 32'hFFFF_FFFF);
        send_word(32'd7, 32'd40, 1'b0);
        send_word(32'd6, 32'd40, 1'b1);
        drain();
        // single method set
        setup(1'b1, 8'd1, 32'd20000, 48'd50, 32'd1);
        send_word(32'd0, 32'd0, 1'b1);
        drain();
    endtask

    task automatic test_overflow();
        setup(1'b1, 8'd2, 32'd5, 48'd100000, 32'd64);
        for (int i = 0; i < NMAX; i++) send_word(32'd10, 32'd30, 1'b0);
        send_word(32'd10, 32'd30, 1'b1);   // dropped but closes the set
        drain();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 240) begin
            int n, mode;
            setup($urandom_range(7) != 0, 8'($urandom_range(255)), $urandom,
                  ($urandom_range(3) == 0) ? {$urandom, 16'($urandom)} : 48'($urandom_range(3000)),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(400));
            n = $urandom_range(1, 12);
            mode = $urandom_range(9) < 7 ? 0 : ($urandom_range(1) ? 1 : 2);
            calm = (sent > 100 && sent < 140);
            random_set(n, mode);
            sent += n;
            drain();
        end
        calm = 0;
    endtask

    // results cannot be stalled: check at every strobe
    always @(posedge clk) begin
        if (rst_n) begin
            if (valid) begin
                t_plan_word e;
                if (expected_plan.size() == 0) begin
                    $display("%0t unexpected word %h", $time, got);
                    fails++;
                end else begin
                    e = expected_plan.pop_front();
                    if (e !== got) begin
                        $display("%0t mismatch expected %h actual %h", $time, e, got);
                        fails++;
                    end
                end
            end
            quiet = (valid || (start && !busy) || cfg_we) ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("debug_program_bucket_planner_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        plan_on = 0; param_cnt = 0; line0 = 0; infl_limit = 0;
        bkt_limit = dpbp_pkg::BUCKET_LIMIT_RST;
        loaded = 0; normal_sum = 0; fault = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random();
        drain();
        repeat (20) @(posedge clk);
        if (fails == 0 && expected_plan.size() == 0)
            $display("debug_program_bucket_planner_core verification clean");
        else
            $display("debug_program_bucket_planner_core verification failed");
        $finish;
    end
endmodule
